### hw/rtl/mcpg_pkg.sv
// ----------------------------------------------------------------------------
// mcpg_pkg: shared definitions for the midpoint circle point generator
// Widths, job kinds and the job descriptor passed from front to back.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int RADIUS_BITS = 11;
  localparam int DEC_BITS    = 16;

  // job queue between front and back, depth a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // result index within a job, wide enough for the eight of the longest job
  localparam int IDX_BITS    = 3;

  typedef enum logic [2:0] {
    JOB_CENTRE,
    JOB_AXIS,
    JOB_OCT4,
    JOB_OCT8,
    JOB_DONE
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RADIUS_BITS-1:0] x;
    logic [RADIUS_BITS-1:0] y;
  } job_t;

endpackage

### hw/rtl/mcpg_front.sv
// ----------------------------------------------------------------------------
// mcpg_front: command decoder and circle state
// Accepts items, advances the midpoint state and issues one job per item.
// ----------------------------------------------------------------------------
module mcpg_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [mcpg_pkg::COORD_BITS-1:0] centre_x,
  input  logic [mcpg_pkg::COORD_BITS-1:0] centre_y,
  input  logic [mcpg_pkg::RADIUS_BITS-1:0] radius,
  input  logic                            q_full,
  output logic                            push,
  output mcpg_pkg::job_t                  job
);
  import mcpg_pkg::*;

  logic [RADIUS_BITS-1:0]     cur_x, cur_x_next;
  logic [RADIUS_BITS-1:0]     cur_y, cur_y_next;
  logic signed [DEC_BITS-1:0] decision, decision_next;
  logic [COORD_BITS-1:0]      held_centre_x, held_centre_x_next;
  logic [COORD_BITS-1:0]      held_centre_y, held_centre_y_next;
  logic                       active, active_next;

  logic signed [DEC_BITS-1:0] two_y, two_x;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // work out the next circle state and the job for this item
  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    decision_next      = decision;
    held_centre_x_next = held_centre_x;
    held_centre_y_next = held_centre_y;
    active_next        = active;
    two_y              = '0;
    two_x              = '0;
    job.kind           = JOB_DONE;

    if (!cmd) begin
      held_centre_x_next = centre_x;
      held_centre_y_next = centre_y;
      cur_x_next         = radius;
      cur_y_next         = '0;
      decision_next      = DEC_BITS'(1) - DEC_BITS'(radius);
      active_next        = 1'b1;
      job.kind           = (radius == '0) ? JOB_CENTRE : JOB_AXIS;
    end else if (!active || (cur_x <= cur_y)) begin
      active_next = 1'b0;
      job.kind    = JOB_DONE;
    end else begin
      cur_y_next = cur_y + 1'b1;
      two_y      = DEC_BITS'({cur_y_next, 1'b0});
      if (decision <= 0) begin
        decision_next = decision + two_y + DEC_BITS'(1);
      end else begin
        cur_x_next    = cur_x - 1'b1;
        two_x         = DEC_BITS'({cur_x_next, 1'b0});
        decision_next = decision + two_y - two_x + DEC_BITS'(1);
      end
      if (cur_x_next < cur_y_next) begin
        active_next = 1'b0;
        job.kind    = JOB_DONE;
      end else begin
        job.kind = (cur_x_next == cur_y_next) ? JOB_OCT4 : JOB_OCT8;
      end
    end

    job.cx = held_centre_x_next;
    job.cy = held_centre_y_next;
    job.x  = cur_x_next;
    job.y  = cur_y_next;
  end

  // hold the state, advance it on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      decision      <= '0;
      held_centre_x <= '0;
      held_centre_y <= '0;
      active        <= 1'b0;
    end else if (push) begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      decision      <= decision_next;
      held_centre_x <= held_centre_x_next;
      held_centre_y <= held_centre_y_next;
      active        <= active_next;
    end
  end

endmodule

### hw/rtl/mcpg_queue.sv
// ----------------------------------------------------------------------------
// mcpg_queue: job queue
// Small first-in first-out buffer of job descriptors between front and back.
// ----------------------------------------------------------------------------
module mcpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mcpg_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output mcpg_pkg::job_t head
);
  import mcpg_pkg::*;

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full       = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/mcpg_back.sv
// ----------------------------------------------------------------------------
// mcpg_back: point expander
// Turns the job at the queue head into its results, one per cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module mcpg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  mcpg_pkg::job_t                      head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mcpg_pkg::OUT_BITS-1:0] point_x,
  output logic signed [mcpg_pkg::OUT_BITS-1:0] point_y,
  output logic                                point_valid,
  output logic                                last_of_run,
  output logic                                circle_done
);
  import mcpg_pkg::*;

  logic [IDX_BITS-1:0]    idx;
  logic                   load;
  logic                   last;
  logic                   pv;
  logic                   done;
  logic [RADIUS_BITS-1:0] mag_a, mag_b;
  logic                   neg_a, neg_b;
  logic                   zero_a, zero_b;
  logic [OUT_BITS-1:0]    off_x, off_y;
  logic [OUT_BITS-1:0]    sum_x, sum_y;

  function automatic logic [OUT_BITS-1:0] offset(input logic [RADIUS_BITS-1:0] m,
                                                 input logic neg, input logic zero);
    logic [OUT_BITS-1:0] ext;
    ext = zero ? '0 : OUT_BITS'(m);
    return neg ? (~ext + 1'b1) : ext;
  endfunction

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && last;

  // pick the offset pair for the current result of the head job
  always_comb begin
    mag_a  = head.x;
    mag_b  = head.y;
    neg_a  = 1'b0;
    neg_b  = 1'b0;
    zero_a = 1'b0;
    zero_b = 1'b0;
    pv     = 1'b1;
    done   = 1'b0;
    last   = 1'b0;
    unique case (head.kind)
      JOB_CENTRE: begin
        zero_a = 1'b1;
        zero_b = 1'b1;
        last   = 1'b1;
      end
      JOB_AXIS: begin
        mag_a  = head.x;
        mag_b  = head.x;
        zero_a = idx[1];
        zero_b = !idx[1];
        neg_a  = idx[0];
        neg_b  = idx[0];
        last   = (idx[1:0] == 2'd3);
      end
      JOB_OCT4, JOB_OCT8: begin
        mag_a = idx[2] ? head.y : head.x;
        mag_b = idx[2] ? head.x : head.y;
        neg_a = idx[0];
        neg_b = idx[1];
        last  = (head.kind == JOB_OCT4) ? (idx == IDX_BITS'(3)) : (idx == IDX_BITS'(7));
      end
      JOB_DONE: begin
        pv   = 1'b0;
        done = 1'b1;
        last = 1'b1;
      end
      default: begin
        pv   = 1'b0;
        last = 1'b1;
      end
    endcase
    off_x = offset(mag_a, neg_a, zero_a);
    off_y = offset(mag_b, neg_b, zero_b);
    sum_x = pv ? (OUT_BITS'(head.cx) + off_x) : '0;
    sum_y = pv ? (OUT_BITS'(head.cy) + off_y) : '0;
  end

  // step through the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

  // hold the output register until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      point_x     <= $signed(sum_x);
      point_y     <= $signed(sum_y);
      point_valid <= pv;
      last_of_run <= last;
      circle_done <= done;
    end
  end

  // a done result carries no pixel and closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && circle_done |-> last_of_run && !point_valid)
    else $error("done result without last or with pixel");

  // a job being expanded stays at the queue head
  a_idx_head: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> head_valid)
    else $error("job left the queue mid-expansion");

  // a load that does not finish the job advances the index by one
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    load && !last |=> idx == $past(idx) + 1'b1)
    else $error("result index skipped");

  // a finished job restarts the index
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0)
    else $error("result index not cleared after job");

endmodule

### hw/rtl/midpoint_circle_point_generator_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_unit: midpoint circle rasteriser
// Start and step items in, one pixel result per cycle out while the receiver is ready.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): cmd 0 starts a circle from centre_x,
//   centre_y and radius; cmd 1 advances one step of the midpoint loop.
//   Output channel (out_valid/out_ready): one result per handshake, with
//   last_of_run marking the final result of each item.
//   A start gives four results (one for radius 0); a step gives eight, four
//   on the diagonal, or one done result once the circle is complete.
//   An accepted item's job is written into the job queue; its first result
//   is then registered at the output, if the queue was empty and the output
//   register is free. The result channel emits one result per cycle while
//   the receiver is ready, so a full step occupies it for its eight results;
//   the front takes one item per cycle while the four-entry queue has room.
//   When the receiver stalls the output register holds its result, the
//   queue fills and in_ready drops once four jobs are waiting.
//   Reset (rst, synchronous) empties the queue and output register and
//   clears the circle state: a step before any start reports done.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic [mcpg_pkg::COORD_BITS-1:0]      centre_x,
  input  logic [mcpg_pkg::COORD_BITS-1:0]      centre_y,
  input  logic [mcpg_pkg::RADIUS_BITS-1:0]     radius,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mcpg_pkg::OUT_BITS-1:0] point_x,
  output logic signed [mcpg_pkg::OUT_BITS-1:0] point_y,
  output logic                                 point_valid,
  output logic                                 last_of_run,
  output logic                                 circle_done
);
  import mcpg_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic head_valid;
  job_t push_job;
  job_t head;

  mcpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .centre_x (centre_x),
    .centre_y (centre_y),
    .radius   (radius),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  mcpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  mcpg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .last_of_run (last_of_run),
    .circle_done (circle_done)
  );

endmodule

### test/circle_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_tb_pkg: shared codes for the circle generator testbench
// Item command codes used by the stimulus and by the checker.
// ----------------------------------------------------------------------------
package circle_tb_pkg;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } circle_cmd_t;

endpackage

### test/circle_point_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_point_checker: pixel predictor and result comparator
// Watches both channels of the circle generator. Each accepted item runs
// through an independent midpoint circle model that queues the pixels it
// should produce; each accepted result is compared with the oldest of them.
// ----------------------------------------------------------------------------
module circle_point_checker
  import mcpg_pkg::*;
  import circle_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   cmd,
  input  logic [COORD_BITS-1:0]  centre_x,
  input  logic [COORD_BITS-1:0]  centre_y,
  input  logic [RADIUS_BITS-1:0] radius,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_BITS-1:0]    point_x,
  input  logic [OUT_BITS-1:0]    point_y,
  input  logic                   point_valid,
  input  logic                   last_of_run,
  input  logic                   circle_done,
  output int                     error_count,
  output int                     pending_count,
  output int                     result_count
);

  typedef struct packed {
    logic [OUT_BITS-1:0] px;
    logic [OUT_BITS-1:0] py;
    logic                pix;
    logic                last;
    logic                done;
  } pixel_t;

  // circle state of the model
  int                    circ_x;
  int                    circ_y;
  int                    circ_dec;
  logic [COORD_BITS-1:0] held_cx;
  logic [COORD_BITS-1:0] held_cy;
  bit                    circ_active;

  pixel_t pending_pixels[$];

  function automatic pixel_t octant_pixel(int dx, int dy);
    pixel_t p;
    p.px   = OUT_BITS'(int'(held_cx) + dx);
    p.py   = OUT_BITS'(int'(held_cy) + dy);
    p.pix  = 1'b1;
    p.last = 1'b0;
    p.done = 1'b0;
    return p;
  endfunction

  // work out the pixels one item causes and queue them in order
  task automatic rasterise_item(input logic c, input logic [COORD_BITS-1:0] cx,
                                input logic [COORD_BITS-1:0] cy,
                                input logic [RADIUS_BITS-1:0] r);
    pixel_t run[$];
    pixel_t fin;
    bit     finished;
    finished = 1'b0;
    if (c == CMD_START) begin
      held_cx     = cx;
      held_cy     = cy;
      circ_x      = int'(r);
      circ_y      = 0;
      circ_dec    = 1 - circ_x;
      circ_active = 1'b1;
      if (circ_x == 0) begin
        run.push_back(octant_pixel(0, 0));
      end else begin
        run.push_back(octant_pixel(circ_x, 0));
        run.push_back(octant_pixel(-circ_x, 0));
        run.push_back(octant_pixel(0, circ_x));
        run.push_back(octant_pixel(0, -circ_x));
      end
    end else begin
      if (!circ_active || circ_x <= circ_y) begin
        finished = 1'b1;
      end else begin
        circ_y++;
        if (circ_dec <= 0) begin
          circ_dec = circ_dec + 2 * circ_y + 1;
        end else begin
          circ_x--;
          circ_dec = circ_dec + 2 * circ_y - 2 * circ_x + 1;
        end
        finished = (circ_x < circ_y);
      end
      if (finished) begin
        circ_active = 1'b0;
        fin = '0;
        fin.done = 1'b1;
        run.push_back(fin);
      end else begin
        run.push_back(octant_pixel(circ_x, circ_y));
        run.push_back(octant_pixel(-circ_x, circ_y));
        run.push_back(octant_pixel(circ_x, -circ_y));
        run.push_back(octant_pixel(-circ_x, -circ_y));
        if (circ_x != circ_y) begin
          run.push_back(octant_pixel(circ_y, circ_x));
          run.push_back(octant_pixel(-circ_y, circ_x));
          run.push_back(octant_pixel(circ_y, -circ_x));
          run.push_back(octant_pixel(-circ_y, -circ_x));
        end
      end
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_pixels.push_back(run[i]);
  endtask

  // compare accepted results first, then predict from accepted items
  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (rst) begin
      circ_x      = 0;
      circ_y      = 0;
      circ_dec    = 0;
      held_cx     = '0;
      held_cy     = '0;
      circ_active = 1'b0;
      pending_pixels.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        got = '{point_x, point_y, point_valid, last_of_run, circle_done};
        if (pending_pixels.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result x=%0d y=%0d pix=%0b last=%0b done=%0b",
                   $time, $signed(got.px), $signed(got.py), got.pix, got.last, got.done);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            error_count++;
            $display("%0t: mismatch, expected x=%0d y=%0d pix=%0b last=%0b done=%0b",
                     $time, $signed(want.px), $signed(want.py), want.pix, want.last,
                     want.done);
            $display("%0t:           actual   x=%0d y=%0d pix=%0b last=%0b done=%0b",
                     $time, $signed(got.px), $signed(got.py), got.pix, got.last,
                     got.done);
          end
        end
      end
      if (in_valid && in_ready) rasterise_item(cmd, centre_x, centre_y, radius);
    end
    pending_count = pending_pixels.size();
  end

endmodule

### test/midpoint_circle_point_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_unit_tb: top of the circle generator bench
// Drives start and step items through four idling phases, one of them with a
// long receiver hold, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator_unit_tb;
  import mcpg_pkg::*;
  import circle_tb_pkg::*;

  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 200;
  localparam int PHASE_ITEMS   = 72;
  localparam int DRAIN_CYCLES  = 20;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   cmd;
  logic [COORD_BITS-1:0]  centre_x;
  logic [COORD_BITS-1:0]  centre_y;
  logic [RADIUS_BITS-1:0] radius;
  logic                   out_valid;
  logic                   out_ready;
  logic [OUT_BITS-1:0]    point_x;
  logic [OUT_BITS-1:0]    point_y;
  logic                   point_valid;
  logic                   last_of_run;
  logic                   circle_done;

  int error_count;
  int pending_count;
  int result_count;

  int tx_gap_pct;
  int rx_stall_pct;
  bit hold_request;
  bit hold_taken;
  int hold_left;
  int idle_cycles;
  int starts_sent;
  int steps_sent;

  midpoint_circle_point_generator_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_valid (point_valid),
    .last_of_run (last_of_run),
    .circle_done (circle_done)
  );

  circle_point_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .centre_x      (centre_x),
    .centre_y      (centre_y),
    .radius        (radius),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_valid   (point_valid),
    .last_of_run   (last_of_run),
    .circle_done   (circle_done),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold when one is requested
  initial begin
    out_ready  = 1'b0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, hold it until accepted, return at the following falling edge
  task automatic send_item(input circle_cmd_t c, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy,
                           input logic [RADIUS_BITS-1:0] r);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    centre_x <= cx;
    centre_y <= cy;
    radius   <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (c == CMD_START) starts_sent++;
    else steps_sent++;
  endtask

  // step fields are ignored by the block, so fill them with noise
  task automatic step_circle();
    send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              RADIUS_BITS'($urandom));
  endtask

  // mostly complete circles, some cut short, some stray steps
  task automatic run_random(input int n_items);
    int sent;
    int roll;
    int r;
    int steps;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        steps = 1 + $urandom_range(2);
        repeat (steps) step_circle();
        sent += steps;
      end else begin
        if (roll < 70) begin
          r     = $urandom_range(30);
          steps = (r * 3) / 4 + 2 + $urandom_range(1);
        end else begin
          r     = $urandom_range(2047);
          steps = $urandom_range(6);
        end
        send_item(CMD_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                  RADIUS_BITS'(r));
        repeat (steps) step_circle();
        sent += steps + 1;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_START;
    centre_x     = '0;
    centre_y     = '0;
    radius       = '0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_request = 1'b0;
    starts_sent  = 0;
    steps_sent   = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: idle steps, zero radius, extremes, diagonal and crossing ends
    step_circle();
    send_item(CMD_START, 12'd0, 12'd0, 11'd0);
    step_circle();
    step_circle();
    send_item(CMD_START, 12'd4095, 12'd4095, 11'd2047);
    step_circle();
    step_circle();
    send_item(CMD_START, 12'd0, 12'd0, 11'd2047);
    step_circle();
    step_circle();
    send_item(CMD_START, 12'd2048, 12'd2048, 11'd1);
    step_circle();
    step_circle();
    send_item(CMD_START, 12'd100, 12'd200, 11'd2);
    step_circle();
    step_circle();
    step_circle();
    send_item(CMD_START, 12'd4095, 12'd0, 11'd3);
    repeat (3) step_circle();
    send_item(CMD_START, 12'd0, 12'd4095, 11'd5);
    step_circle();
    send_item(CMD_START, 12'd1234, 12'd2345, 11'd0);
    step_circle();

    // no idling, opening with a long receiver hold so the input backs up
    hold_request = 1'b1;
    run_random(PHASE_ITEMS);

    // sender idle about half the time
    tx_gap_pct = 49;
    run_random(PHASE_ITEMS);

    // receiver stalling about half the time
    tx_gap_pct   = 0;
    rx_stall_pct = 49;
    run_random(PHASE_ITEMS);

    // light idling on both sides
    tx_gap_pct   = 8;
    rx_stall_pct = 8;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d start and %0d step items over four idling phases,",
             starts_sent, steps_sent);
    $display("         including a long output hold; %0d results compared.",
             result_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mcpg_pkg.sv
hw/rtl/mcpg_front.sv
hw/rtl/mcpg_queue.sv
hw/rtl/mcpg_back.sv
hw/rtl/midpoint_circle_point_generator_unit.sv
test/circle_tb_pkg.sv
test/circle_point_checker.sv
test/midpoint_circle_point_generator_unit_tb.sv
